// ----- design/quic_initial_header_parser_macros.svh -----
// Assertion macros for the QUIC initial header parser.
// Included by the modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef QUIC_INITIAL_HEADER_PARSER_MACROS_SVH
`define QUIC_INITIAL_HEADER_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define QIHP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qihp check failed");

// next-cycle implication
`define QIHP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qihp check failed");

`else

`define QIHP_ASSERT_NOW(lbl, ante, cons)
`define QIHP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- design/qihp_pkg.sv -----
// Shared types and constants for the QUIC initial header parser.
// No dependencies; used by every module of the block.
package qihp_pkg;

    localparam int MAX_ID_LEN = 20;
    localparam logic [31:0] VERSION_DEFAULT = 32'h0000_0001;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_VERSION = 3'd1,
        PH_DLEN    = 3'd2,
        PH_DID     = 3'd3,
        PH_SLEN    = 3'd4,
        PH_SID     = 3'd5,
        PH_DONE    = 3'd6,
        PH_FAILED  = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_TRUNC   = 3'd2,
        ST_BADVER  = 3'd3,
        ST_TOOLONG = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        KIND_DEST   = 2'd0,
        KIND_SRC    = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_kind       result_kind;
        logic [7:0]  id_byte;
        logic [4:0]  id_byte_position;
        t_status     parse_status;
        logic [31:0] version_seen;
        logic [4:0]  dest_id_length;
        logic [4:0]  source_id_length;
        logic        end_of_run;
    } t_out_item;

    // up to two results per input item: an ID byte, then the status
    typedef struct packed {
        logic      id_valid;
        t_out_item id_item;
        logic      st_valid;
        t_out_item st_item;
    } t_results;

endpackage

// ----- design/qihp_parser.sv -----
// Header parse state and per-byte next-state / result logic.
// Depends on qihp_pkg and the assertion macro header.
`include "quic_initial_header_parser_macros.svh"

module qihp_parser
    import qihp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  t_in_item    i_item,
    input  logic [31:0] i_version,
    output t_results    o_res
);

    t_phase      r_phase, n_phase;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_ver, n_ver;
    logic [4:0]  r_dlen, n_dlen;
    logic [4:0]  r_slen, n_slen;
    t_status     r_fail, n_fail;

    logic [7:0]  b;
    logic [31:0] ver_shift;
    logic [4:0]  cnt_inc;
    logic [4:0]  id_len;
    t_status     status;

    assign b         = i_item.data_byte;
    assign ver_shift = {r_ver[23:0], b};
    assign cnt_inc   = r_cnt + 5'd1;
    assign id_len    = (r_phase == PH_DID) ? r_dlen : r_slen;

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_ver   = r_ver;
        n_dlen  = r_dlen;
        n_slen  = r_slen;
        n_fail  = r_fail;
        o_res   = '0;

        case (r_phase)
            PH_FIRST: begin
                if (!b[7]) begin
                    n_fail  = ST_SHORT;
                    n_phase = PH_FAILED;
                end else begin
                    n_phase = PH_VERSION;
                    n_cnt   = '0;
                end
            end
            PH_VERSION: begin
                n_ver = ver_shift;
                n_cnt = cnt_inc;
                if (cnt_inc == 5'd4) begin
                    n_cnt = '0;
                    if (ver_shift != i_version) begin
                        n_fail  = ST_BADVER;
                        n_phase = PH_FAILED;
                    end else begin
                        n_phase = PH_DLEN;
                    end
                end
            end
            PH_DLEN, PH_SLEN: begin
                if (b > 8'(MAX_ID_LEN)) begin
                    n_fail  = ST_TOOLONG;
                    n_phase = PH_FAILED;
                end else begin
                    n_cnt = '0;
                    if (r_phase == PH_DLEN) begin
                        n_dlen  = b[4:0];
                        n_phase = (b == 8'd0) ? PH_SLEN : PH_DID;
                    end else begin
                        n_slen  = b[4:0];
                        n_phase = (b == 8'd0) ? PH_DONE : PH_SID;
                    end
                end
            end
            PH_DID, PH_SID: begin
                o_res.id_valid                 = 1'b1;
                o_res.id_item.result_kind      = (r_phase == PH_DID) ? KIND_DEST : KIND_SRC;
                o_res.id_item.id_byte          = b;
                o_res.id_item.id_byte_position = r_cnt;
                o_res.id_item.end_of_run       = !i_item.last_byte;
                n_cnt = cnt_inc;
                if (cnt_inc >= id_len) begin
                    n_cnt   = '0;
                    n_phase = (r_phase == PH_DID) ? PH_SLEN : PH_DONE;
                end
            end
            default: begin
            end
        endcase

        // status reflects the state after this byte; first failure wins
        if (n_fail != ST_OK) begin
            status = n_fail;
        end else if (n_phase == PH_DONE) begin
            status = ST_OK;
        end else begin
            status = ST_TRUNC;
        end

        if (i_item.last_byte) begin
            o_res.st_valid              = 1'b1;
            o_res.st_item.result_kind   = KIND_STATUS;
            o_res.st_item.parse_status  = status;
            o_res.st_item.version_seen  = n_ver;
            o_res.st_item.dest_id_length   = (status == ST_OK) ? n_dlen : 5'd0;
            o_res.st_item.source_id_length = (status == ST_OK) ? n_slen : 5'd0;
            o_res.st_item.end_of_run    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_cnt   <= '0;
            r_ver   <= '0;
            r_dlen  <= '0;
            r_slen  <= '0;
            r_fail  <= ST_OK;
        end else if (i_take) begin
            if (i_item.last_byte) begin
                // datagram closed: back to the start
                r_phase <= PH_FIRST;
                r_cnt   <= '0;
                r_ver   <= '0;
                r_dlen  <= '0;
                r_slen  <= '0;
                r_fail  <= ST_OK;
            end else begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_ver   <= n_ver;
                r_dlen  <= n_dlen;
                r_slen  <= n_slen;
                r_fail  <= n_fail;
            end
        end
    end

    `QIHP_ASSERT_NOW(a_failed_has_code, r_phase == PH_FAILED, r_fail != ST_OK)
    `QIHP_ASSERT_NEXT(a_last_clears, i_take && i_item.last_byte, r_phase == PH_FIRST && r_fail == ST_OK)

endmodule

// ----- design/qihp_out_fifo.sv -----
// Result queue: takes up to two results a cycle, hands out one a cycle unless stalled.
// Depends on qihp_pkg and the assertion macro header.
`include "quic_initial_header_parser_macros.svh"

module qihp_out_fifo
    import qihp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_results  i_res,
    output logic      o_room,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    t_out_item             r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, n_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_CNT_W-1:0] r_count;

    logic                  pop;
    logic [1:0]            push_n;
    t_out_item             slot0;
    logic [FIFO_PTR_W-1:0] wr_plus1;

    assign o_valid  = (r_count != '0);
    assign o_item   = r_mem[r_rd];
    assign pop      = o_valid && !i_stall;
    // room for the worst case of two results
    assign o_room   = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign push_n   = i_push ? (2'(i_res.id_valid) + 2'(i_res.st_valid)) : 2'd0;
    assign slot0    = i_res.id_valid ? i_res.id_item : i_res.st_item;
    assign wr_plus1 = r_wr + FIFO_PTR_W'(1);
    assign n_wr     = r_wr + FIFO_PTR_W'(push_n);

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr] <= slot0;
        end
        if (push_n == 2'd2) begin
            r_mem[wr_plus1] <= i_res.st_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= r_rd + FIFO_PTR_W'(pop);
            r_count <= r_count + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
        end
    end

    `QIHP_ASSERT_NOW(a_count_bound, 1'b1, r_count <= FIFO_CNT_W'(FIFO_DEPTH))
    `QIHP_ASSERT_NOW(a_push_fits, i_push, o_room)

endmodule

// ----- design/quic_initial_header_parser.sv -----
// QUIC v1 long-header parser, one datagram byte per item (qihp_pkg, parser, result queue).
// Path: a byte's results pass the input register, then parse logic into the result queue,
// from which they are handed out.
// Throughput: 1 byte/cycle while the queue has room for two results; the input stalls
// when it lacks that room. A byte with two results drains them one per cycle unless stalled.
// Reset (i_rst_n, synchronous, active low): parser at first byte, queue empty, version 1.
module quic_initial_header_parser
    import qihp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    // accepted-version register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic        r_in_valid;
    t_in_item    r_in_item;
    logic [31:0] r_accepted_version;

    logic        take;
    logic        room;
    t_results    res;

    // Config writes land unchecked; the user must issue them only while the block is idle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accepted_version <= VERSION_DEFAULT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_accepted_version <= i_cfg_data;
        end
    end

    // Input register: holds one item; it moves into the parser when the
    // result queue can take two results.
    assign take       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // Parse state and result generation for the held byte.
    qihp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_item    (r_in_item),
        .i_version (r_accepted_version),
        .o_res     (res)
    );

    // Result queue decouples the output stall from the byte stream.
    qihp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_res   (res),
        .o_room  (room),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_stall (i_out_stall)
    );

endmodule
